// File: rtl/lmcsw_pkg.sv
`default_nettype none
package lmcsw_pkg;

  localparam int NUM_COLUMNS_DEF   = 48;
  localparam int COLS_PER_CHIP_DEF = 24;

  localparam int REQ_TYPE_W = 2;
  localparam int COLUMN_W   = 6;
  localparam int DATA_W     = 16;
  localparam int CMD_W      = 12;
  localparam int ADDR_W     = 7;
  localparam int COL_CMP_W  = 9;

  localparam logic [REQ_TYPE_W-1:0] REQ_COL     = 2'd0;
  localparam logic [REQ_TYPE_W-1:0] REQ_COL_CHG = 2'd1;
  localparam logic [REQ_TYPE_W-1:0] REQ_CMD     = 2'd2;

  localparam logic [2:0] ID_COL_WRITE = 3'b101;
  localparam int ADDR_STEP            = 4;

  localparam int FRAME_W       = 26;
  localparam int CNT_W         = 5;
  localparam int COL_FRAME_LEN = 26;
  localparam int CMD_FRAME_LEN = 12;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  typedef logic [(1 << COLUMN_W)-1:0][ADDR_W-1:0] addr_tbl_t;

  typedef struct packed {
    logic               chip;
    logic               is_cmd;
    logic [FRAME_W-1:0] bits;
  } desc_t;

  // RAM address per column: (column mod cols_per_chip) * 4, low 7 bits kept
  function automatic addr_tbl_t addr_table(int cpc);
    addr_tbl_t t;
    int        r;
    r = 0;
    for (int i = 0; i < (1 << COLUMN_W); i++) begin
      t[i] = ADDR_W'(r * ADDR_STEP);
      r = r + 1;
      if (r == cpc) begin
        r = 0;
      end
    end
    return t;
  endfunction

endpackage
`default_nettype wire

// File: rtl/lmcsw_front.sv
`default_nettype none
module lmcsw_front
  import lmcsw_pkg::*;
#(
  parameter int NUM_COLUMNS   = NUM_COLUMNS_DEF,
  parameter int COLS_PER_CHIP = COLS_PER_CHIP_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_push,
  output logic                       in_full,
  input  wire logic [REQ_TYPE_W-1:0] in_req_type,
  input  wire logic [COLUMN_W-1:0]   in_column,
  input  wire logic [DATA_W-1:0]     in_column_data,
  input  wire logic [CMD_W-1:0]      in_command_word,
  input  wire logic                  in_command_chip,
  output logic                       q_push,
  output desc_t                      q_desc,
  input  wire logic                  q_full
);

  localparam int IDX_W = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1;
  localparam addr_tbl_t ADDR_TBL = addr_table(COLS_PER_CHIP);

  logic [DATA_W-1:0]     shadow_mem [NUM_COLUMNS];
  logic [NUM_COLUMNS-1:0] wr_vld_r;

  logic                  s_vld_r;
  logic [REQ_TYPE_W-1:0] s_req_r;
  logic [COLUMN_W-1:0]   s_col_r;
  logic [DATA_W-1:0]     s_data_r;
  logic [CMD_W-1:0]      s_cmd_r;
  logic                  s_cchip_r;
  logic [DATA_W-1:0]     rd_r;
  logic                  rdv_r;

  logic                  acc;
  logic [COL_CMP_W-1:0]  in_col_ext;
  logic                  in_rng;
  logic [IDX_W-1:0]      in_idx;
  logic [COL_CMP_W-1:0]  s_col_ext;
  logic                  s_rng;
  logic [IDX_W-1:0]      s_idx;
  logic [DATA_W-1:0]     shadow;
  logic                  col_ok;
  logic                  cmd_ok;
  logic                  s_done;
  logic                  wr_en;
  logic [DATA_W-1:0]     data_rev;
  logic                  s_chip;

  assign acc        = in_push && !in_full;
  assign in_col_ext = {{(COL_CMP_W-COLUMN_W){1'b0}}, in_column};
  assign in_rng     = in_col_ext < COL_CMP_W'(NUM_COLUMNS);
  assign in_idx     = in_rng ? in_col_ext[IDX_W-1:0] : '0;
  assign s_col_ext  = {{(COL_CMP_W-COLUMN_W){1'b0}}, s_col_r};
  assign s_rng      = s_col_ext < COL_CMP_W'(NUM_COLUMNS);
  assign s_idx      = s_rng ? s_col_ext[IDX_W-1:0] : '0;

  assign shadow = rdv_r ? rd_r : '0;
  assign col_ok = s_rng && ((s_req_r == REQ_COL) ||
                            ((s_req_r == REQ_COL_CHG) && (shadow != s_data_r)));
  assign cmd_ok = s_req_r == REQ_CMD;
  assign s_done = s_vld_r && (!(col_ok || cmd_ok) || !q_full);
  assign wr_en  = s_vld_r && col_ok && !q_full;
  assign in_full = s_vld_r && !s_done;
  assign q_push  = s_vld_r && (col_ok || cmd_ok) && !q_full;
  assign s_chip  = s_col_r >= COLUMN_W'(COLS_PER_CHIP);

  always_comb begin
    for (int i = 0; i < DATA_W; i++) begin
      data_rev[i] = s_data_r[DATA_W-1-i];
    end
  end

  always_comb begin
    if (cmd_ok) begin
      q_desc.chip   = s_cchip_r;
      q_desc.is_cmd = 1'b1;
      q_desc.bits   = {s_cmd_r, {(FRAME_W-CMD_W){1'b0}}};
    end else begin
      q_desc.chip   = s_chip;
      q_desc.is_cmd = 1'b0;
      q_desc.bits   = {ID_COL_WRITE, ADDR_TBL[s_col_r], data_rev};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_vld_r  <= 1'b0;
      wr_vld_r <= '0;
    end else begin
      if (acc) begin
        s_vld_r <= 1'b1;
      end else if (s_done) begin
        s_vld_r <= 1'b0;
      end
      if (wr_en) begin
        wr_vld_r[s_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      shadow_mem[s_idx] <= s_data_r;
    end
    if (acc) begin
      s_req_r   <= in_req_type;
      s_col_r   <= in_column;
      s_data_r  <= in_column_data;
      s_cmd_r   <= in_command_word;
      s_cchip_r <= in_command_chip;
      // same-column write in flight: forward it
      if (wr_en && (s_idx == in_idx)) begin
        rd_r  <= s_data_r;
        rdv_r <= 1'b1;
      end else begin
        rd_r  <= shadow_mem[in_idx];
        rdv_r <= wr_vld_r[in_idx];
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/lmcsw_queue.sv
`default_nettype none
module lmcsw_queue
  import lmcsw_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  q_push,
  input  wire desc_t q_wdata,
  output logic       q_full,
  input  wire logic  q_pop,
  output desc_t      q_rdata,
  output logic       q_vld
);

  desc_t                data_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r;
  logic [Q_PTR_W-1:0]   rd_ptr_r;
  logic [Q_CNT_W-1:0]   cnt_r;
  logic [Q_CNT_W-1:0]   cnt_nxt;

  assign q_full  = cnt_r == Q_CNT_W'(Q_DEPTH);
  assign q_vld   = cnt_r != '0;
  assign q_rdata = data_r[rd_ptr_r];
  assign cnt_nxt = cnt_r + Q_CNT_W'(q_push) - Q_CNT_W'(q_pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (q_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (q_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) begin
      data_r[wr_ptr_r] <= q_wdata;
    end
  end

endmodule
`default_nettype wire

// File: rtl/lmcsw_back.sv
`default_nettype none
module lmcsw_back
  import lmcsw_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  q_vld,
  input  wire desc_t q_desc,
  output logic       q_pop,
  output logic       out_empty,
  input  wire logic  out_pop,
  output logic       out_chip_sel,
  output logic       out_serial_bit,
  output logic       out_frame_end
);

  logic               busy_r;
  logic               busy_nxt;
  logic [FRAME_W-1:0] sh_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               chip_r;
  logic               ovld_r;
  logic               ochip_r;
  logic               obit_r;
  logic               oend_r;

  logic slot_free;
  logic emit;
  logic last;
  logic load;

  assign slot_free = !ovld_r || out_pop;
  assign emit      = busy_r && slot_free;
  assign last      = emit && (cnt_r == CNT_W'(1));
  assign load      = q_vld && (!busy_r || last);
  assign q_pop     = load;

  always_comb begin
    busy_nxt = busy_r;
    if (load) begin
      busy_nxt = 1'b1;
    end else if (last) begin
      busy_nxt = 1'b0;
    end
  end

  assign out_empty      = !ovld_r;
  assign out_chip_sel   = ochip_r;
  assign out_serial_bit = obit_r;
  assign out_frame_end  = oend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ovld_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      if (emit) begin
        ovld_r <= 1'b1;
      end else if (out_pop) begin
        ovld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sh_r   <= q_desc.bits;
      chip_r <= q_desc.chip;
      cnt_r  <= q_desc.is_cmd ? CNT_W'(CMD_FRAME_LEN) : CNT_W'(COL_FRAME_LEN);
    end else if (emit) begin
      sh_r  <= {sh_r[FRAME_W-2:0], 1'b0};
      cnt_r <= cnt_r - CNT_W'(1);
    end
    if (emit) begin
      ochip_r <= chip_r;
      obit_r  <= sh_r[FRAME_W-1];
      oend_r  <= cnt_r == CNT_W'(1);
    end
  end

endmodule
`default_nettype wire

// File: rtl/led_matrix_column_serial_writer.sv
// Channel   Handshake         Payload
// in        in_push / in_full  in_req_type, in_column, in_column_data,
//                              in_command_word, in_command_chip
// out       out_pop / out_empty out_chip_sel, out_serial_bit, out_frame_end
//
// Serial bits leave one per cycle while out_pop keeps up; a column frame is
// 26 bits, a command 12; a skipped or ignored request never waits on the queue.
// The front looks up the shadow column store (registered read) and queues
// frame descriptors two deep, so requests are taken while a frame shifts out.
// Reset is synchronous; per-column valid bits make the shadow read as zero
// after reset, with no clearing pass.
// A held-off pop stalls the serialiser, then the queue, then in_full.
`default_nettype none
module led_matrix_column_serial_writer
  import lmcsw_pkg::*;
#(
  parameter int NUM_COLUMNS   = NUM_COLUMNS_DEF,
  parameter int COLS_PER_CHIP = COLS_PER_CHIP_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_push,
  output logic                       in_full,
  input  wire logic [REQ_TYPE_W-1:0] in_req_type,
  input  wire logic [COLUMN_W-1:0]   in_column,
  input  wire logic [DATA_W-1:0]     in_column_data,
  input  wire logic [CMD_W-1:0]      in_command_word,
  input  wire logic                  in_command_chip,
  output logic                       out_empty,
  input  wire logic                  out_pop,
  output logic                       out_chip_sel,
  output logic                       out_serial_bit,
  output logic                       out_frame_end
);

  logic  f_push;
  desc_t f_desc;
  logic  f_full;
  logic  b_pop;
  desc_t b_desc;
  logic  b_vld;

  lmcsw_front #(
    .NUM_COLUMNS   (NUM_COLUMNS),
    .COLS_PER_CHIP (COLS_PER_CHIP)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_req_type     (in_req_type),
    .in_column       (in_column),
    .in_column_data  (in_column_data),
    .in_command_word (in_command_word),
    .in_command_chip (in_command_chip),
    .q_push          (f_push),
    .q_desc          (f_desc),
    .q_full          (f_full)
  );

  lmcsw_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_push  (f_push),
    .q_wdata (f_desc),
    .q_full  (f_full),
    .q_pop   (b_pop),
    .q_rdata (b_desc),
    .q_vld   (b_vld)
  );

  lmcsw_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_vld          (b_vld),
    .q_desc         (b_desc),
    .q_pop          (b_pop),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_chip_sel   (out_chip_sel),
    .out_serial_bit (out_serial_bit),
    .out_frame_end  (out_frame_end)
  );

endmodule
`default_nettype wire
